@@ design/per_pixel_temporal_median_unit_defines.svh @@
// Assertion macros shared by the temporal median design.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef PER_PIXEL_TEMPORAL_MEDIAN_UNIT_DEFINES_SVH
`define PER_PIXEL_TEMPORAL_MEDIAN_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PPTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pptm_pkg.sv @@
// Types and constants of the per-pixel temporal median unit.
// Depends on nothing; used by every module of the design.
`default_nettype none

package pptm_pkg;

  // Window length in frames and number of pixel positions per frame.
  localparam int WINDOW       = 15;
  localparam int FRAME_PIXELS = 65536;

  // Derived widths and positions.
  localparam int ADDR_W = $clog2(FRAME_PIXELS);
  localparam int AGE_W  = $clog2(WINDOW);
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int MID    = WINDOW / 2;
  localparam int NEWEST = WINDOW - 1;

  typedef logic [7:0]       pix_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One position's full window, sorted by value.
  typedef struct packed {
    pix_t [WINDOW-1:0] vals;
    age_t [WINDOW-1:0] ages;
  } row_t;

  // A window with its oldest entry taken out and the ages already aged.
  typedef struct packed {
    pix_t [WINDOW-2:0] vals;
    age_t [WINDOW-2:0] ages;
  } rem_t;

endpackage

`default_nettype wire

@@ design/pptm_evict.sv @@
// Removes the oldest entry from a window and ages the rest by one.
// Depends on pptm_pkg.
`default_nettype none

module pptm_evict
  import pptm_pkg::*;
(
  input  row_t src_row,
  output rem_t rem_row
);

  logic [WINDOW-1:0] sel;
  logic [IDX_W-1:0]  old_idx;

  // An entry is the oldest when no earlier entry has a strictly smaller age
  // and no later entry has an age at or below its own.
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      sel[k] = 1'b1;
      for (int j = 0; j < WINDOW; j++) begin
        if (j < k && src_row.ages[j] < src_row.ages[k]) begin
          sel[k] = 1'b0;
        end
        if (j > k && src_row.ages[j] <= src_row.ages[k]) begin
          sel[k] = 1'b0;
        end
      end
    end
  end

  // Encode the one-hot selection into an index.
  always_comb begin
    old_idx = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (sel[k]) begin
        old_idx = old_idx | IDX_W'(k);
      end
    end
  end

  // Close the gap left by the oldest entry; ages stop at zero.
  always_comb begin
    for (int n = 0; n < WINDOW - 1; n++) begin
      if (IDX_W'(n) >= old_idx) begin
        rem_row.vals[n] = src_row.vals[n+1];
        rem_row.ages[n] = (src_row.ages[n+1] == '0) ? '0 : src_row.ages[n+1] - 1'b1;
      end else begin
        rem_row.vals[n] = src_row.vals[n];
        rem_row.ages[n] = (src_row.ages[n] == '0) ? '0 : src_row.ages[n] - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/pptm_insert.sv @@
// Inserts the new pixel word after all strictly smaller entries of a window.
// Depends on pptm_pkg.
`default_nettype none

module pptm_insert
  import pptm_pkg::*;
(
  input  rem_t rem_row,
  input  pix_t new_val,
  output row_t new_row
);

  logic [WINDOW-2:0] lt;
  logic [WINDOW-2:0] sfx;

  // Compare every remaining entry with the new value.
  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      lt[k] = rem_row.vals[k] < new_val;
    end
  end

  // The insert position lies above entry k when any entry from k up is smaller.
  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      sfx[k] = |(lt >> k);
    end
  end

  // Build the updated row: entries below the position stay, the new value
  // takes the position, and the entries above it move up by one.
  always_comb begin
    if (sfx[0]) begin
      new_row.vals[0] = rem_row.vals[0];
      new_row.ages[0] = rem_row.ages[0];
    end else begin
      new_row.vals[0] = new_val;
      new_row.ages[0] = AGE_W'(NEWEST);
    end
    for (int k = 1; k < WINDOW - 1; k++) begin
      if (sfx[k]) begin
        new_row.vals[k] = rem_row.vals[k];
        new_row.ages[k] = rem_row.ages[k];
      end else if (sfx[k-1]) begin
        new_row.vals[k] = new_val;
        new_row.ages[k] = AGE_W'(NEWEST);
      end else begin
        new_row.vals[k] = rem_row.vals[k-1];
        new_row.ages[k] = rem_row.ages[k-1];
      end
    end
    if (sfx[WINDOW-2]) begin
      new_row.vals[WINDOW-1] = new_val;
      new_row.ages[WINDOW-1] = AGE_W'(NEWEST);
    end else begin
      new_row.vals[WINDOW-1] = rem_row.vals[WINDOW-2];
      new_row.ages[WINDOW-1] = rem_row.ages[WINDOW-2];
    end
  end

endmodule

`default_nettype wire

@@ design/per_pixel_temporal_median_unit.sv @@
// Top level of the per-pixel temporal median unit: window memory and pipeline.
// Depends on pptm_pkg, pptm_evict, pptm_insert and the assertion macro header.
`default_nettype none
`include "per_pixel_temporal_median_unit_defines.svh"

// Per-pixel temporal median. Each input word carries a grey level and its
// row-major position; the unit keeps, for every position, a window of the
// last WINDOW grey levels sorted by value with their ages, drops the oldest,
// inserts the new level and returns the middle entry. The window store is one
// memory of FRAME_PIXELS rows, one row per position (WINDOW values and ages),
// read when a word is accepted and written back at the edge where the word
// leaves the second stage; it is not cleared after reset.
// Instead, every word of the first frame after reset (up to and including the
// word that carries frame_end) starts from a window filled with its own value.
// A word enters every cycle unless out_ready holds the pipeline, and its result
// is registered in stage 3 after stages 1 and 2. The other exception is the
// read-modify-write on the window memory: a word whose pixel_index matches one
// of the two words still ahead of it in the pipeline waits until that word has
// been written back.
module per_pixel_temporal_median_unit
  import pptm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_pixel_value,
  input  wire logic [15:0] in_pixel_index,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_median_value,
  output logic             out_frame_end_out
);

  // Window store, one row per pixel position.
  row_t  win_mem_r [FRAME_PIXELS];

  // Stage 1: row read back from memory plus the word itself.
  logic  v1_r;
  pix_t  val1_r;
  addr_t addr1_r;
  logic  fend1_r;
  logic  prime1_r;
  row_t  rd_row_r;

  // Stage 2: window with the oldest entry removed.
  logic  v2_r;
  rem_t  rem2_r;
  pix_t  val2_r;
  addr_t addr2_r;
  logic  fend2_r;

  // Stage 3: output register.
  logic  v3_r;
  pix_t  med3_r;
  logic  fend3_r;

  logic  primed_r;
  logic  primed_nxt;

  logic  en1;
  logic  en2;
  logic  en3;
  logic  hazard;
  logic  in_acc;
  logic  wr_en;
  addr_t in_addr;
  row_t  src_row;
  rem_t  rem_row;
  row_t  new_row;

  // Positions are taken modulo the frame size.
  assign in_addr = in_pixel_index[ADDR_W-1:0];

  // Pipeline advance: each stage moves when it is empty or the next one moves.
  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  // A word must not read a row that an earlier word has yet to write back.
  assign hazard = (v1_r && (addr1_r == in_addr)) || (v2_r && (addr2_r == in_addr));
  assign in_ready = en1 && !hazard;
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = v2_r && en3;

  // The priming phase ends with the first end-of-frame word.
  assign primed_nxt = primed_r || (in_acc && in_frame_end);

  // Valid bits and the priming flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      primed_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_acc;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      primed_r <= primed_nxt;
    end
  end

  // Window memory: read on acceptance, write back as stage 2 moves on.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= win_mem_r[in_addr];
    end
    if (wr_en) begin
      win_mem_r[addr2_r] <= new_row;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      val1_r   <= in_pixel_value;
      addr1_r  <= in_addr;
      fend1_r  <= in_frame_end;
      prime1_r <= !primed_r;
    end
  end

  // During priming the window starts filled with the word's own value.
  always_comb begin
    src_row = rd_row_r;
    if (prime1_r) begin
      for (int k = 0; k < WINDOW; k++) begin
        src_row.vals[k] = val1_r;
        src_row.ages[k] = AGE_W'(k);
      end
    end
  end

  pptm_evict u_evict (
    .src_row (src_row),
    .rem_row (rem_row)
  );

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      rem2_r  <= rem_row;
      val2_r  <= val1_r;
      addr2_r <= addr1_r;
      fend2_r <= fend1_r;
    end
  end

  pptm_insert u_insert (
    .rem_row (rem2_r),
    .new_val (val2_r),
    .new_row (new_row)
  );

  // Output register holds the middle entry of the updated window.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      med3_r  <= new_row.vals[MID];
      fend3_r <= fend2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_median_value  = med3_r;
  assign out_frame_end_out = fend3_r;

  // Two words in flight never share a row, so no write-back is overtaken.
  `PPTM_ASSERT_IMP(a_no_row_overlap, v1_r && v2_r, addr1_r != addr2_r,
                   "two words in flight share a window row")
  // Once the first frame has ended, priming never resumes.
  `PPTM_ASSERT_NXT(a_primed_sticky, primed_r, primed_r,
                   "priming flag dropped after the first frame")
  // An accepted end-of-frame word ends the priming phase.
  `PPTM_ASSERT_NXT(a_fend_primes, in_acc && in_frame_end, primed_r && v1_r && fend1_r,
                   "end-of-frame word did not end priming")
  // Every write-back presents its result in the output register next cycle.
  `PPTM_ASSERT_NXT(a_wb_to_out, wr_en, v3_r,
                   "window write-back without a result word")

endmodule

`default_nettype wire

@@ test/tb_per_pixel_temporal_median_unit.sv @@
// Self-checking testbench for per_pixel_temporal_median_unit.
// Words go in from a queue under bursty traffic, and a local model of every window checks each
// median. Depends on pptm_pkg and the RTL of the unit only.
`timescale 1ns / 100ps

module tb_per_pixel_temporal_median_unit;
  import pptm_pkg::*;

  localparam int RANDOM_WORDS = 580;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_START   = 300;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 8;

  // One input word as it sits in the send queue.
  typedef struct packed {
    pix_t        value;
    logic [15:0] index;
    logic        frame_end;
  } pixel_word_t;

  // One expected result word.
  typedef struct packed {
    pix_t median;
    logic frame_end;
  } median_word_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_pixel_value = 8'h00;
  logic [15:0] in_pixel_index = 16'h0000;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_median_value;
  logic        out_frame_end_out;

  pixel_word_t  pending_pixels[$];
  median_word_t expected_medians[$];
  addr_t        known_positions[$];

  // Local copy of the window store; only positions that were written are present.
  row_t pixel_windows[int];
  logic windows_primed = 1'b0;

  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_cycles = 0;
  rx_mode_t rx_mode = RX_FREE;
  pixel_word_t  next_word;
  median_word_t want;

  per_pixel_temporal_median_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_value   (in_pixel_value),
    .in_pixel_index   (in_pixel_index),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median_value (out_median_value),
    .out_frame_end_out(out_frame_end_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one pixel to its window and returns the new middle entry.
  function automatic pix_t update_pixel_window(input pix_t value, input addr_t idx,
                                               input logic fend);
    row_t row;
    pix_t kept_vals [WINDOW-1];
    age_t kept_ages [WINDOW-1];
    int   k;
    int   n;
    int   oldest;
    int   min_age;
    int   slot;
    row = pixel_windows.exists(int'(idx)) ? pixel_windows[int'(idx)] : '0;
    // Until the first end of frame, every pixel restarts its window from its own value.
    if (!windows_primed) begin
      for (k = 0; k < WINDOW; k++) begin
        row.vals[k] = value;
        row.ages[k] = age_t'(k);
      end
    end
    // The oldest entry is the last one holding the smallest age.
    oldest  = 0;
    min_age = 16;
    for (k = 0; k < WINDOW; k++) begin
      if (int'(row.ages[k]) <= min_age) begin
        min_age = int'(row.ages[k]);
        oldest  = k;
      end
    end
    // Drop it and age the rest, never below zero.
    n = 0;
    for (k = 0; k < WINDOW; k++) begin
      if (k != oldest) begin
        kept_vals[n] = row.vals[k];
        kept_ages[n] = (row.ages[k] != '0) ? row.ages[k] - 1'b1 : '0;
        n++;
      end
    end
    // The new value goes after every strictly smaller one.
    slot = 0;
    for (k = 0; k < WINDOW - 1; k++) begin
      if (kept_vals[k] < value) slot = k + 1;
    end
    n = 0;
    for (k = 0; k < WINDOW; k++) begin
      if (k == slot) begin
        row.vals[k] = value;
        row.ages[k] = age_t'(NEWEST);
      end else begin
        row.vals[k] = kept_vals[n];
        row.ages[k] = kept_ages[n];
        n++;
      end
    end
    pixel_windows[int'(idx)] = row;
    if (fend) windows_primed = 1'b1;
    return row.vals[MID];
  endfunction

  task automatic queue_pixel(input pix_t value, input logic [15:0] index, input logic fend);
    pending_pixels.push_back('{value: value, index: index, frame_end: fend});
  endtask

  // Picks a grey level: extremes, a narrow band full of equal values, or anything.
  function automatic pix_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return pix_t'($urandom_range(120, 123));
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: bursts of words with idle gaps, taken from the send queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left == 0 && pending_pixels.size() != 0) begin
        next_word = pending_pixels.pop_front();
        in_pixel_value <= next_word.value;
        in_pixel_index <= next_word.index;
        in_frame_end   <= next_word.frame_end;
        in_valid       <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver: stall mode is redrawn at random periodically, with one long hold-off to back up the pipe.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycles = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:  out_ready <= ($urandom_range(0, 1) != 0);
          default:  out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: predict each accepted input word, then check each accepted result word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_medians.push_back('{
          median:    update_pixel_window(in_pixel_value, in_pixel_index, in_frame_end),
          frame_end: in_frame_end});
      end
      if (out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: result word with nothing expected: median %0d frame_end %0b",
                   $time, out_median_value, out_frame_end_out);
          error_count++;
        end else begin
          want = expected_medians.pop_front();
          if (out_median_value !== want.median) begin
            $display("%0t: median_value expected %0d actual %0d",
                     $time, want.median, out_median_value);
            error_count++;
          end
          if (out_frame_end_out !== want.frame_end) begin
            $display("%0t: frame_end_out expected %0b actual %0b",
                     $time, want.frame_end, out_frame_end_out);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    addr_t       idx;
    addr_t       prev1;
    addr_t       prev2;
    logic [15:0] rand_idx;
    int          i;

    // First frame: every position used later is primed here. Position 0 is hit twice so the
    // second word restarts its window, and the end-of-frame word is itself primed.
    known_positions = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    queue_pixel(8'h00, 16'h0000, 1'b0);
    queue_pixel(8'hFF, 16'h0000, 1'b0);
    queue_pixel(8'hFF, 16'hFFFF, 1'b0);
    queue_pixel(8'h55, 16'h5555, 1'b0);
    queue_pixel(8'hAA, 16'hAAAA, 1'b0);
    for (i = 0; i < 12; i++) begin
      rand_idx = 16'($urandom_range(0, 65535));
      known_positions.push_back(rand_idx);
      queue_pixel((i == 11) ? 8'h80 : pick_value(), rand_idx, i == 11);
    end

    // Short directed run after priming: back-to-back hits on one position and extremes.
    queue_pixel(8'h00, 16'hFFFF, 1'b0);
    queue_pixel(8'hFF, 16'hFFFF, 1'b0);
    queue_pixel(8'h80, 16'hFFFF, 1'b1);
    queue_pixel(8'h00, 16'h0000, 1'b0);
    queue_pixel(8'hFF, 16'hFFFF, 1'b0);
    queue_pixel(8'h00, 16'h0000, 1'b0);
    queue_pixel(8'hFF, 16'h5555, 1'b1);

    // Random words on primed positions only, often repeating a recent position so that the
    // read-modify-write hazard comes up at both distances.
    prev1 = 16'h5555;
    prev2 = 16'h0000;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    idx = prev1;
        2:       idx = prev2;
        default: idx = known_positions[$urandom_range(0, known_positions.size() - 1)];
      endcase
      queue_pixel(pick_value(), idx, $urandom_range(0, 31) == 0);
      prev2 = prev1;
      prev1 = idx;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so the sender's updates have settled.
    while (pending_pixels.size() != 0 || in_valid) @(negedge clk);
    while (expected_medians.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_medians.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ per_pixel_temporal_median_unit.f @@
+incdir+design
design/pptm_pkg.sv
design/pptm_evict.sv
design/pptm_insert.sv
design/per_pixel_temporal_median_unit.sv
test/tb_per_pixel_temporal_median_unit.sv
